// File: rtl/core/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the LWE phase decryption block.
// ----------------------------------------------------------------------------
package lpd_pkg;

    // Default torus width and the fixed field widths of the streams and registers.
    localparam int LPD_TORUS_BITS = 32;
    localparam int LPD_WORD_BITS  = 32;
    localparam int LPD_OUT_BITS   = 16;
    localparam int LPD_PMOD_BITS  = 17;
    localparam int LPD_ADDR_BITS  = 4;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_IDX_MODE  = 2'd0,
        REG_IDX_DELTA = 2'd1,
        REG_IDX_PMOD  = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PHASE,
        ST_QSTART,
        ST_QWAIT,
        ST_ROUND,
        ST_MSTART,
        ST_MWAIT,
        ST_WRITE
    } lpd_state_t;

    typedef enum logic [1:0] {
        RES_BIT,
        RES_ZERO,
        RES_MOD
    } result_sel_t;

    typedef struct packed {
        logic        take_input;
        logic        form_phase;
        logic        div_start;
        logic        div_second;
        logic        round_quot;
        logic        write_result;
        result_sel_t result_sel;
    } lpd_cmd_t;

    typedef struct packed {
        logic body_taken;
        logic div_done;
        logic mode_int;
        logic div_by_zero;
        logic out_free;
    } lpd_status_t;

endpackage

// File: rtl/core/lpd_divider.sv
// ----------------------------------------------------------------------------
// lpd_divider
// Restoring radix-2 divider, one quotient bit per cycle, 32-bit divisor.
// ----------------------------------------------------------------------------
module lpd_divider
    import lpd_pkg::*;
#(
    parameter int DIVIDEND_BITS = LPD_TORUS_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [LPD_WORD_BITS-1:0] divisor,
    output logic                     done,
    output logic [DIVIDEND_BITS-1:0] quotient,
    output logic [LPD_WORD_BITS-1:0] remainder
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic [DIVIDEND_BITS-1:0] quo_reg, quo_next;
    logic [LPD_WORD_BITS-1:0] rem_reg, rem_next;
    logic [LPD_WORD_BITS-1:0] dvs_reg, dvs_next;
    logic [CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic                     done_reg, done_next;

    logic [LPD_WORD_BITS:0]   trial;
    logic [LPD_WORD_BITS:0]   diff;
    logic                     fits;

    // The remainder always stays below the divisor, so 32 bits hold it.
    assign trial = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CNT_BITS'(DIVIDEND_BITS);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? diff[LPD_WORD_BITS-1:0] : trial[LPD_WORD_BITS-1:0];
            quo_next  = {quo_reg[DIVIDEND_BITS-2:0], fits};
            cnt_next  = cnt_reg - CNT_BITS'(1);
            done_next = (cnt_reg == CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/core/lpd_datapath.sv
// ----------------------------------------------------------------------------
// lpd_datapath
// Product register, phase accumulator, rounding and the output register.
// ----------------------------------------------------------------------------
module lpd_datapath
    import lpd_pkg::*;
#(
    parameter int TORUS_BITS = LPD_TORUS_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lpd_cmd_t                 cmd,
    output lpd_status_t              status,
    input  logic                     in_valid,
    input  logic [LPD_WORD_BITS-1:0] cipher_word,
    input  logic [LPD_WORD_BITS-1:0] key_word,
    input  logic                     is_body,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic [LPD_OUT_BITS-1:0]  plain_value,
    input  logic                     decrypt_mode,
    input  logic [LPD_WORD_BITS-1:0] delta,
    input  logic [LPD_PMOD_BITS-1:0] pt_modulus
);

    logic [2*LPD_WORD_BITS-1:0] prod_full;
    logic [TORUS_BITS-1:0]      prod_reg, prod_next;
    logic                       prod_valid_reg, prod_valid_next;
    logic [TORUS_BITS-1:0]      acc_reg, acc_next;
    logic [LPD_WORD_BITS-1:0]   body_reg, body_next;
    logic [TORUS_BITS-1:0]      phase_reg, phase_next;
    logic [TORUS_BITS-1:0]      quot_reg, quot_next;
    logic                       out_valid_reg, out_valid_next;
    logic [LPD_OUT_BITS-1:0]    out_data_reg, out_data_next;

    logic                       mask_taken;
    logic                       body_taken;
    logic                       round_up;
    logic                       phase_positive;
    logic [TORUS_BITS-1:0]      div_dividend;
    logic [LPD_WORD_BITS-1:0]   div_divisor;
    logic                       div_done;
    logic [TORUS_BITS-1:0]      div_quot;
    logic [LPD_WORD_BITS-1:0]   div_rem;

    assign mask_taken = in_valid && cmd.take_input && !is_body;
    assign body_taken = in_valid && cmd.take_input && is_body;

    assign prod_full = 64'(cipher_word) * 64'(key_word);

    // The divider is shared: first phase by delta, then the rounded
    // quotient by the plain modulus.
    assign div_dividend = cmd.div_second ? quot_reg : phase_reg;
    assign div_divisor  = cmd.div_second ? LPD_WORD_BITS'(pt_modulus) : delta;

    lpd_divider #(
        .DIVIDEND_BITS (TORUS_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Half up: round when twice the remainder reaches delta.
    assign round_up       = {div_rem, 1'b0} >= {1'b0, delta};
    assign phase_positive = (phase_reg != '0) && !phase_reg[TORUS_BITS-1];

    always_comb
    begin
        prod_next       = prod_full[TORUS_BITS-1:0];
        prod_valid_next = mask_taken;
        body_next       = body_taken ? cipher_word : body_reg;
        phase_next      = phase_reg;
        quot_next       = quot_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;

        if (cmd.form_phase)
        begin
            phase_next = acc_reg + TORUS_BITS'(body_reg);
            acc_next   = '0;
        end
        else if (prod_valid_reg)
        begin
            acc_next = acc_reg - prod_reg;
        end

        if (cmd.round_quot)
        begin
            quot_next = div_quot + TORUS_BITS'(round_up);
        end

        if (cmd.write_result)
        begin
            out_valid_next = 1'b1;
            case (cmd.result_sel)
                RES_BIT:  out_data_next = LPD_OUT_BITS'(phase_positive);
                RES_MOD:  out_data_next = div_rem[LPD_OUT_BITS-1:0];
                default:  out_data_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            acc_reg        <= acc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        body_reg     <= body_next;
        phase_reg    <= phase_next;
        quot_reg     <= quot_next;
        out_data_reg <= out_data_next;
    end

    assign status.body_taken  = body_taken;
    assign status.div_done    = div_done;
    assign status.mode_int    = decrypt_mode;
    assign status.div_by_zero = (delta == '0) || (pt_modulus == '0);
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign plain_value = out_data_reg;

endmodule

// File: rtl/core/lpd_controller.sv
// ----------------------------------------------------------------------------
// lpd_controller
// Sequencer for the body item: phase, in integer mode two divisions with rounding between them, write-out.
// ----------------------------------------------------------------------------
module lpd_controller
    import lpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lpd_status_t status,
    output lpd_cmd_t    cmd
);

    lpd_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd.take_input   = 1'b0;
        cmd.form_phase   = 1'b0;
        cmd.div_start    = 1'b0;
        cmd.div_second   = 1'b0;
        cmd.round_quot   = 1'b0;
        cmd.write_result = 1'b0;
        if (!status.mode_int)
        begin
            cmd.result_sel = RES_BIT;
        end
        else if (status.div_by_zero)
        begin
            cmd.result_sel = RES_ZERO;
        end
        else
        begin
            cmd.result_sel = RES_MOD;
        end

        case (state_reg)
            ST_IDLE:
            begin
                cmd.take_input = 1'b1;
                if (status.body_taken)
                begin
                    state_next = ST_PHASE;
                end
            end
            ST_PHASE:
            begin
                cmd.form_phase = 1'b1;
                if (status.mode_int && !status.div_by_zero)
                begin
                    state_next = ST_QSTART;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_QSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_QWAIT;
            end
            ST_QWAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round_quot = 1'b1;
                state_next     = ST_MSTART;
            end
            ST_MSTART:
            begin
                cmd.div_start  = 1'b1;
                cmd.div_second = 1'b1;
                state_next     = ST_MWAIT;
            end
            ST_MWAIT:
            begin
                cmd.div_second = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (status.out_free)
                begin
                    cmd.write_result = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/lwe_phase_decrypt.sv
// ----------------------------------------------------------------------------
// lwe_phase_decrypt
// LWE ciphertext decryption: streamed multiply-accumulate, then decode.
// ----------------------------------------------------------------------------
// Mask items (tlast low) are taken one per cycle; each product is registered
// and subtracted from the phase accumulator on the next cycle. The body item
// (tlast high) closes the ciphertext and blocks the input until its result is
// in the output register. In bit mode the body goes from the phase state
// straight to the write state. In integer mode the shared one-bit-per-cycle
// divider runs twice (phase by delta, then the rounded quotient by the plain
// modulus) before the write state. Either way the body also waits while an
// earlier result still sits unread in the output register. A finished result
// may wait in the output register while the next ciphertext's mask items
// stream in.
module lwe_phase_decrypt
    import lpd_pkg::*;
#(
    parameter int TORUS_BITS = LPD_TORUS_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // s_tdata fields from bit 0: cipher_word[31:0], key_word[63:32]
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [2*LPD_WORD_BITS-1:0] s_tdata,
    // s_tlast carries is_body
    input  logic                     s_tlast,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // m_tdata fields from bit 0: plain_value[15:0]
    output logic [LPD_OUT_BITS-1:0]  m_tdata,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [LPD_ADDR_BITS-1:0] paddr,
    input  logic [LPD_WORD_BITS-1:0] pwdata,
    output logic [LPD_WORD_BITS-1:0] prdata,
    output logic                     pready
);

    logic                     mode_reg, mode_next;
    logic [LPD_WORD_BITS-1:0] delta_reg, delta_next;
    logic [LPD_PMOD_BITS-1:0] pmod_reg, pmod_next;
    logic                     cfg_write;

    lpd_cmd_t                 cmd;
    lpd_status_t              status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        mode_next  = mode_reg;
        delta_next = delta_reg;
        pmod_next  = pmod_reg;
        if (cfg_write)
        begin
            case (paddr[3:2])
                REG_IDX_MODE:  mode_next  = pwdata[0];
                REG_IDX_DELTA: delta_next = pwdata;
                REG_IDX_PMOD:  pmod_next  = pwdata[LPD_PMOD_BITS-1:0];
                default:       mode_next  = mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_IDX_MODE:  prdata = LPD_WORD_BITS'(mode_reg);
            REG_IDX_DELTA: prdata = delta_reg;
            REG_IDX_PMOD:  prdata = LPD_WORD_BITS'(pmod_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            delta_reg <= 32'd536870912;
            pmod_reg  <= 17'd8;
        end
        else
        begin
            mode_reg  <= mode_next;
            delta_reg <= delta_next;
            pmod_reg  <= pmod_next;
        end
    end

    lpd_controller u_controller (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    lpd_datapath #(
        .TORUS_BITS (TORUS_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_valid      (s_tvalid),
        .cipher_word   (s_tdata[LPD_WORD_BITS-1:0]),
        .key_word      (s_tdata[2*LPD_WORD_BITS-1:LPD_WORD_BITS]),
        .is_body       (s_tlast),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .plain_value   (m_tdata),
        .decrypt_mode  (mode_reg),
        .delta         (delta_reg),
        .pt_modulus    (pmod_reg)
    );

    assign s_tready = cmd.take_input;

endmodule

// File: rtl/core/lpd_checker.sv
// ----------------------------------------------------------------------------
// lpd_checker
// Port-level assertions for lwe_phase_decrypt, attached by bind.
// ----------------------------------------------------------------------------
module lpd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // Bodies taken whose results have not yet been delivered.
    logic [1:0] pending_reg, pending_next;
    logic       body_in;
    logic       res_out;

    assign body_in = s_tvalid && s_tready && s_tlast;
    assign res_out = m_tvalid && m_tready;

    always_comb
    begin
        pending_next = pending_reg;
        if (body_in && !res_out)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (res_out && !body_in)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    a_body_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        body_in |=> !s_tready)
        else $error("input still ready right after a body transaction");

    a_mask_streams: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast |=> s_tready)
        else $error("mask transaction stalled the input");

    a_result_has_body: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (pending_reg != 2'd0))
        else $error("result presented without a pending body");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two bodies outstanding");

endmodule

bind lwe_phase_decrypt lpd_checker u_lpd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/lwe_phase_decrypt_tb.sv
// ----------------------------------------------------------------------------
// lwe_phase_decrypt_tb
// Self-checking bench for the LWE phase decryption block.
// ----------------------------------------------------------------------------
// Ciphertexts are queued as mask transactions followed by one body
// transaction. A clocked driver streams them in random bursts. A clocked
// monitor stalls the output on rotating ready patterns and checks every
// result against a local decoder that tracks the phase and register settings.
// The registers are rewritten between runs of traffic, once the block has
// gone idle. The settings cover both modes, the delta and modulus extremes,
// and a zero delta and a zero modulus.
// ----------------------------------------------------------------------------
module lwe_phase_decrypt_tb;
    import lpd_pkg::*;

    localparam int DRAIN_CYCLES = 2*LPD_TORUS_BITS + 16;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct {
        logic [31:0] cipher_word;
        logic [31:0] key_word;
        logic        is_body;
    } cipher_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // s_tdata fields from bit 0: cipher_word[31:0], key_word[63:32]
    logic [63:0] s_tdata = '0;
    // s_tlast carries is_body
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // m_tdata fields from bit 0: plain_value[15:0]
    logic [15:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Register settings as the decoder sees them.
    logic        cfg_int_mode = 1'b0;
    logic [31:0] cfg_delta = 32'd536870912;
    logic [16:0] cfg_pmod = 17'd8;
    logic [31:0] phase_acc = '0;

    cipher_item_t pending_items[$];
    logic [15:0]  expected_plain[$];
    cipher_item_t next_item;

    logic        sender_steady = 1'b0;
    logic        receiver_steady = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_age = 0;
    logic [15:0] want_plain;

    int fail_count = 0;
    int cycle_count = 0;
    int ciphertext_count = 0;
    int mask_count = 0;
    int results_checked = 0;
    int settings_count = 1;

    lwe_phase_decrypt dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [15:0] decode_phase(input logic [31:0] phase);
        logic [63:0] quot;
        logic [63:0] rem;
        logic [63:0] divisor;
        if (!cfg_int_mode)
            return {15'd0, (phase != 32'd0) && !phase[31]};
        if (cfg_delta == 32'd0 || cfg_pmod == 17'd0)
            return 16'd0;
        divisor = {32'd0, cfg_delta};
        quot = {32'd0, phase} / divisor;
        rem = {32'd0, phase} % divisor;
        // Round half up: bump when the remainder is at least half of delta.
        if (rem >= divisor - rem)
            quot = quot + 64'd1;
        quot = quot % {47'd0, cfg_pmod};
        return quot[15:0];
    endfunction

    task automatic absorb_item(input logic [31:0] cipher_word, input logic [31:0] key_word,
                               input logic is_body);
        if (!is_body)
        begin
            phase_acc = phase_acc - cipher_word * key_word;
            mask_count++;
        end
        else
        begin
            expected_plain.push_back(decode_phase(phase_acc + cipher_word));
            phase_acc = '0;
            ciphertext_count++;
        end
    endtask

    task automatic push_item(input logic [31:0] cipher_word, input logic [31:0] key_word,
                             input logic is_body);
        cipher_item_t it;
        it.cipher_word = cipher_word;
        it.key_word = key_word;
        it.is_body = is_body;
        pending_items.push_back(it);
    endtask

    // Queues one ciphertext. When aimed, the body is chosen so that the phase
    // lands exactly on the given value.
    task automatic queue_ciphertext(input int n_masks, input bit aimed, input logic [31:0] aim);
        logic [31:0] acc;
        logic [31:0] cw;
        logic [31:0] kw;
        acc = '0;
        for (int k = 0; k < n_masks; k++)
        begin
            cw = $urandom;
            kw = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 1);
            acc = acc - cw * kw;
            push_item(cw, kw, 1'b0);
        end
        push_item(aimed ? aim - acc : $urandom, $urandom, 1'b1);
    endtask

    function automatic logic [31:0] pick_aim();
        logic [32:0] half;
        logic [31:0] base;
        if (!cfg_int_mode || cfg_delta == 32'd0)
        begin
            case ($urandom_range(0, 5))
                0: return 32'd0;
                1: return 32'h8000_0000;
                2: return 32'h7FFF_FFFF;
                3: return $urandom_range(1, 4);
                4: return 32'd0 - $urandom_range(1, 4);
                default: return $urandom;
            endcase
        end
        half = ({1'b0, cfg_delta} + 33'd1) >> 1;
        base = $urandom_range(0, cfg_pmod) * cfg_delta;
        case ($urandom_range(0, 4))
            0: return base;
            1: return base + half[31:0];
            2: return base + half[31:0] - 32'd1;
            3: return base + cfg_delta - 32'd1;
            default: return base + ($urandom % cfg_delta);
        endcase
    endfunction

    task automatic queue_random(input int n_items);
        int queued;
        int n_masks;
        queued = 0;
        while (queued < n_items)
        begin
            n_masks = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 6);
            if ($urandom_range(0, 2) == 0)
                queue_ciphertext(n_masks, 1'b0, '0);
            else
                queue_ciphertext(n_masks, 1'b1, pick_aim());
            queued += n_masks + 1;
        end
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_IDX_MODE:  cfg_int_mode = value[0];
            REG_IDX_DELTA: cfg_delta = value;
            REG_IDX_PMOD:  cfg_pmod = value[16:0];
            default: ;
        endcase
    endtask

    // Waits until every queued item is sent and every result is out, then lets the divider
    // settle before anything else happens.
    task automatic wait_drain();
        while (pending_items.size() != 0 || s_tvalid || expected_plain.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_setting(input logic mode, input logic [31:0] delta,
                               input logic [31:0] pmod, input int n_items);
        reg_write(REG_IDX_MODE, {31'd0, mode});
        reg_write(REG_IDX_DELTA, delta);
        reg_write(REG_IDX_PMOD, pmod);
        settings_count++;
        sender_steady <= ($urandom_range(0, 3) == 0);
        receiver_steady <= ($urandom_range(0, 3) == 0);
        queue_random(n_items);
        wait_drain();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                absorb_item(s_tdata[31:0], s_tdata[63:32], s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    s_tvalid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_items.size() != 0)
                begin
                    next_item = pending_items.pop_front();
                    s_tdata <= {next_item.key_word, next_item.cipher_word};
                    s_tlast <= next_item.is_body;
                    s_tvalid <= 1'b1;
                    if (burst_left > 1)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(1, 24);
                        if (sender_steady)
                            gap_left <= 0;
                        else if ($urandom_range(0, 3) == 0)
                            gap_left <= $urandom_range(10, 40);
                        else
                            gap_left <= $urandom_range(0, 5);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            ready_pattern <= 16'hFFFF;
            pattern_age <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_plain.size() == 0)
                begin
                    $error("plain_value: no result expected, got %0d", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want_plain = expected_plain.pop_front();
                    results_checked++;
                    if (m_tdata !== want_plain)
                    begin
                        $error("plain_value mismatch: expected %0d, actual %0d",
                               want_plain, m_tdata);
                        fail_count++;
                    end
                end
            end
            m_tready <= receiver_steady ? 1'b1 : ready_pattern[0];
            if (pattern_age == 15)
            begin
                ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
                pattern_age <= 0;
            end
            else
            begin
                ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
                pattern_age <= pattern_age + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("lwe_phase_decrypt_tb failed");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bit mode from reset: the sign boundaries of the phase.
        queue_ciphertext(0, 1'b1, 32'd0);
        queue_ciphertext(0, 1'b1, 32'd1);
        queue_ciphertext(0, 1'b1, 32'h7FFF_FFFF);
        queue_ciphertext(0, 1'b1, 32'h8000_0000);
        queue_ciphertext(0, 1'b1, 32'hFFFF_FFFF);
        push_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        push_item(32'd0, 32'hFFFF_FFFF, 1'b1);
        push_item(32'hFFFF_FFFF, 32'd1, 1'b0);
        push_item(32'd0, 32'd0, 1'b1);
        wait_drain();

        // Integer mode with the reset delta and modulus: rounding edges and
        // a rounded quotient that wraps past the top of the modulus.
        reg_write(REG_IDX_MODE, 32'd1);
        queue_ciphertext(0, 1'b1, 32'h1000_0000);
        queue_ciphertext(0, 1'b1, 32'h0FFF_FFFF);
        queue_ciphertext(0, 1'b1, 32'hF000_0000);
        queue_ciphertext(0, 1'b1, 32'hFFFF_FFFF);
        queue_ciphertext(0, 1'b1, 32'h6000_0000);
        push_item(32'hFFFF_FFFF, 32'd0, 1'b0);
        push_item(32'h2000_0000, 32'hFFFF_FFFF, 1'b1);
        queue_random(150);
        wait_drain();

        run_setting(1'b1, 32'd1, 32'd65536, 180);
        run_setting(1'b1, 32'h8000_0000, 32'd2, 180);
        run_setting(1'b1, 32'hFFFF_FFFF, 32'h1_FFFF, 150);
        run_setting(1'b1, 32'd0, 32'd8, 60);
        run_setting(1'b1, 32'd12345, 32'd0, 60);
        run_setting(1'b1, $urandom, 32'd1, 80);
        run_setting(1'b0, $urandom, $urandom_range(0, 131071), 220);
        run_setting(1'b1, $urandom_range(1, 1 << 20), $urandom_range(1, 65536), 180);
        for (int k = 0; k < 3; k++)
            run_setting(1'b1, $urandom_range(1, 32'h8000_0000), $urandom_range(1, 65536), 120);

        if (expected_plain.size() != 0)
        begin
            $error("plain_value: %0d results never arrived", expected_plain.size());
            fail_count++;
        end
        $display("Decrypted %0d ciphertexts (%0d mask words) under %0d register settings.",
                 ciphertext_count, mask_count, settings_count);
        $display("Checked %0d results, %0d errors.", results_checked, fail_count);
        if (fail_count == 0)
            $display("lwe_phase_decrypt_tb passed");
        else
            $display("lwe_phase_decrypt_tb failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/lpd_pkg.sv
rtl/core/lpd_divider.sv
rtl/core/lpd_datapath.sv
rtl/core/lpd_controller.sv
rtl/core/lwe_phase_decrypt.sv
rtl/core/lpd_checker.sv
tb/lwe_phase_decrypt_tb.sv
